// ===== src/rr_pkg.sv =====
// Shared constants, state encoding and control struct for the round-robin
// completion time block. No dependencies.
package rr_pkg;

  localparam int unsigned MAX_PROCS_DEF = 32;
  localparam int unsigned TIME_BITS_DEF = 16;

  localparam int unsigned ID_W      = 8;
  localparam int unsigned IN_TIME_W = 16;
  localparam int unsigned Q_W       = 16;
  localparam int unsigned OUT_W     = 22;

  localparam logic [Q_W-1:0]   Q_RESET = Q_W'(4);
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SHIFT,
    ST_PLACE,
    ST_COPY,
    ST_ADM_RD,
    ST_ADM_CMP,
    ST_DISPATCH,
    ST_JUMP,
    ST_POP,
    ST_SLICE,
    ST_REQUEUE,
    ST_OUT_RD,
    ST_OUT_LD
  } rr_state_e;

  typedef struct packed {
    logic load;
    logic last;
    logic overflow;
  } res_ctl_t;

endpackage

// ===== src/rr_in_if.sv =====
// Input channel: one process description per transfer.
// Depends on rr_pkg for field widths.
interface rr_in_if;
  import rr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      process_id;
  logic [IN_TIME_W-1:0] arrival_time;
  logic [IN_TIME_W-1:0] burst_time;
  logic                 last_process;

  modport source (output valid, process_id, arrival_time, burst_time, last_process,
                  input ready);
  modport sink   (input valid, process_id, arrival_time, burst_time, last_process,
                  output ready);
endinterface

// ===== src/rr_res_if.sv =====
// Result channel: one per-process timing record per transfer.
// Depends on rr_pkg for field widths.
interface rr_res_if;
  import rr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  process_id_res;
  logic [OUT_W-1:0] completion_time;
  logic [OUT_W-1:0] turnaround_time;
  logic [OUT_W-1:0] waiting_time;
  logic             overflow;
  logic             last_result;

  modport source (output valid, process_id_res, completion_time, turnaround_time,
                  waiting_time, overflow, last_result,
                  input ready);
  modport sink   (input valid, process_id_res, completion_time, turnaround_time,
                  waiting_time, overflow, last_result,
                  output ready);
endinterface

// ===== src/rr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rr_sched.sv =====
// Load sorter and round-robin sequencer built around four RAMs
// (process table, remaining time, finish time, ready ring). Uses rr_pkg, rr_ram.
module rr_sched #(
  parameter int unsigned MAX_PROCS = rr_pkg::MAX_PROCS_DEF,
  parameter int unsigned TIME_BITS = rr_pkg::TIME_BITS_DEF,
  localparam int unsigned IDX_W    = $clog2(MAX_PROCS),
  localparam int unsigned CT_W     = TIME_BITS + IDX_W + 1,
  localparam int unsigned ENT_W    = rr_pkg::ID_W + 2 * TIME_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rr_in_if.sink                 in_i,
  input  logic [rr_pkg::Q_W-1:0] quantum_i,
  input  logic                  res_free_i,
  output rr_pkg::res_ctl_t      res_ctl_o,
  output logic [ENT_W-1:0]      ent_o,
  output logic [CT_W-1:0]       fin_o
);
  import rr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned SL_W  = (TIME_BITS > Q_W) ? TIME_BITS : Q_W;

  rr_state_e state_q, state_d;

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     ctr_q, ctr_d;
  logic [CNT_W-1:0]     na_q, na_d;
  logic [CNT_W-1:0]     len_q, len_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [IDX_W-1:0]     tail_q, tail_d;
  logic [CT_W-1:0]      time_q, time_d;
  logic                 dropped_q, dropped_d;
  logic                 last_q, last_d;
  logic                 cpipe_q, cpipe_d;
  logic                 ret_q, ret_d;
  logic [ENT_W-1:0]     item_q, item_d;
  logic [IDX_W-1:0]     p_q, p_d;
  logic [TIME_BITS-1:0] rem_q, rem_d;

  // memory ports
  logic                 ent_we, ent_re;
  logic [IDX_W-1:0]     ent_waddr, ent_raddr;
  logic [ENT_W-1:0]     ent_wdata, ent_rdata;
  logic                 rem_we, rem_re;
  logic [IDX_W-1:0]     rem_waddr, rem_raddr;
  logic [TIME_BITS-1:0] rem_wdata, rem_rdata;
  logic                 fin_we, fin_re;
  logic [IDX_W-1:0]     fin_waddr, fin_raddr;
  logic [CT_W-1:0]      fin_wdata, fin_rdata;
  logic                 ring_we, ring_re;
  logic [IDX_W-1:0]     ring_waddr, ring_raddr;
  logic [IDX_W-1:0]     ring_wdata, ring_rdata;

  logic                 in_ready;
  logic                 set_done;
  logic [ENT_W-1:0]     in_ent;
  logic [TIME_BITS-1:0] rd_arr, item_arr;
  logic [CT_W-1:0]      rd_arr_ct;
  logic [CNT_W-1:0]     pos_m1, pos_m2, ctr_m1, ctr_p1, na_p1;
  logic [IDX_W-1:0]     tail_inc, head_inc;
  logic [Q_W-1:0]       q_eff;
  logic [SL_W-1:0]      rem_x, q_x, slice_x;
  logic [TIME_BITS-1:0] slice;

  rr_ram #(.WIDTH(ENT_W), .DEPTH(MAX_PROCS)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .re_i(ent_re), .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  rr_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_PROCS)) u_rem_ram (
    .clk_i, .we_i(rem_we), .waddr_i(rem_waddr), .wdata_i(rem_wdata),
    .re_i(rem_re), .raddr_i(rem_raddr), .rdata_o(rem_rdata)
  );

  rr_ram #(.WIDTH(CT_W), .DEPTH(MAX_PROCS)) u_fin_ram (
    .clk_i, .we_i(fin_we), .waddr_i(fin_waddr), .wdata_i(fin_wdata),
    .re_i(fin_re), .raddr_i(fin_raddr), .rdata_o(fin_rdata)
  );

  rr_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCS)) u_ring_ram (
    .clk_i, .we_i(ring_we), .waddr_i(ring_waddr), .wdata_i(ring_wdata),
    .re_i(ring_re), .raddr_i(ring_raddr), .rdata_o(ring_rdata)
  );

  assign in_i.ready = in_ready;
  assign ent_o      = ent_rdata;
  assign fin_o      = fin_rdata;

  assign in_ent    = {in_i.process_id, TIME_BITS'(in_i.arrival_time),
                      TIME_BITS'(in_i.burst_time)};
  assign rd_arr    = ent_rdata[2*TIME_BITS-1:TIME_BITS];
  assign item_arr  = item_q[2*TIME_BITS-1:TIME_BITS];
  assign rd_arr_ct = CT_W'(rd_arr);
  assign pos_m1    = pos_q - CNT_W'(1);
  assign pos_m2    = pos_q - CNT_W'(2);
  assign ctr_m1    = ctr_q - CNT_W'(1);
  assign ctr_p1    = ctr_q + CNT_W'(1);
  assign na_p1     = na_q + CNT_W'(1);
  assign tail_inc  = (tail_q == IDX_W'(MAX_PROCS - 1)) ? '0 : tail_q + IDX_W'(1);
  assign head_inc  = (head_q == IDX_W'(MAX_PROCS - 1)) ? '0 : head_q + IDX_W'(1);

  // a zero quantum behaves as one; the slice never exceeds the remaining time
  assign q_eff   = (quantum_i == '0) ? Q_W'(1) : quantum_i;
  assign rem_x   = SL_W'(rem_rdata);
  assign q_x     = SL_W'(q_eff);
  assign slice_x = (rem_x < q_x) ? rem_x : q_x;
  assign slice   = TIME_BITS'(slice_x);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    ctr_d     = ctr_q;
    na_d      = na_q;
    len_d     = len_q;
    head_d    = head_q;
    tail_d    = tail_q;
    time_d    = time_q;
    dropped_d = dropped_q;
    last_d    = last_q;
    cpipe_d   = cpipe_q;
    ret_d     = ret_q;
    item_d    = item_q;
    p_d       = p_q;
    rem_d     = rem_q;
    in_ready  = 1'b0;
    set_done  = 1'b0;
    res_ctl_o = '0;

    ent_we     = 1'b0;
    ent_waddr  = pos_q[IDX_W-1:0];
    ent_wdata  = item_q;
    ent_re     = 1'b0;
    ent_raddr  = na_q[IDX_W-1:0];
    rem_we     = 1'b0;
    rem_waddr  = p_q;
    rem_wdata  = rem_d;
    rem_re     = 1'b0;
    rem_raddr  = ring_rdata;
    fin_we     = 1'b0;
    fin_waddr  = p_q;
    fin_wdata  = time_q;
    fin_re     = 1'b0;
    fin_raddr  = ctr_q[IDX_W-1:0];
    ring_we    = 1'b0;
    ring_waddr = tail_q;
    ring_wdata = na_q[IDX_W-1:0];
    ring_re    = 1'b0;
    ring_raddr = head_q;

    case (state_q)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          item_d = in_ent;
          last_d = in_i.last_process;
          if (cnt_q == CNT_W'(MAX_PROCS)) begin
            dropped_d = 1'b1;
            if (in_i.last_process) state_d = ST_COPY;
          end else if (cnt_q == '0) begin
            ent_we    = 1'b1;
            ent_waddr = '0;
            ent_wdata = in_ent;
            cnt_d     = CNT_W'(1);
            if (in_i.last_process) state_d = ST_COPY;
          end else begin
            // walk down from the tail, moving later arrivals up one slot
            ent_re    = 1'b1;
            ent_raddr = cnt_q[IDX_W-1:0] - IDX_W'(1);
            pos_d     = cnt_q;
            state_d   = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        ent_we = 1'b1;
        if (rd_arr > item_arr) begin
          ent_waddr = pos_q[IDX_W-1:0];
          ent_wdata = ent_rdata;
          pos_d     = pos_m1;
          if (pos_m1 == '0) begin
            state_d = ST_PLACE;
          end else begin
            ent_re    = 1'b1;
            ent_raddr = pos_m2[IDX_W-1:0];
          end
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = last_q ? ST_COPY : ST_LOAD;
        end
      end

      ST_PLACE: begin
        ent_we  = 1'b1;
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = last_q ? ST_COPY : ST_LOAD;
      end

      ST_COPY: begin
        // remaining time starts as the burst: read one entry, write it back next cycle
        if (ctr_q < cnt_q) begin
          ent_re    = 1'b1;
          ent_raddr = ctr_q[IDX_W-1:0];
          ctr_d     = ctr_p1;
          cpipe_d   = 1'b1;
        end else begin
          cpipe_d = 1'b0;
        end
        if (cpipe_q) begin
          rem_we    = 1'b1;
          rem_waddr = ctr_m1[IDX_W-1:0];
          rem_wdata = ent_rdata[TIME_BITS-1:0];
        end
        if (ctr_q == cnt_q) begin
          ctr_d   = '0;
          ret_d   = 1'b0;
          state_d = ST_ADM_RD;
        end
      end

      ST_ADM_RD: begin
        if (na_q < cnt_q) begin
          ent_re  = 1'b1;
          state_d = ST_ADM_CMP;
        end else begin
          state_d = ret_q ? ST_REQUEUE : ST_DISPATCH;
        end
      end

      ST_ADM_CMP: begin
        if (rd_arr_ct <= time_q) begin
          ring_we = 1'b1;
          tail_d  = tail_inc;
          len_d   = len_q + CNT_W'(1);
          na_d    = na_p1;
          if (na_p1 < cnt_q) begin
            ent_re    = 1'b1;
            ent_raddr = na_p1[IDX_W-1:0];
          end else begin
            state_d = ret_q ? ST_REQUEUE : ST_DISPATCH;
          end
        end else begin
          state_d = ret_q ? ST_REQUEUE : ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        if (len_q == '0) begin
          if (na_q >= cnt_q) begin
            if (cnt_q == '0) begin
              set_done = 1'b1;
            end else begin
              state_d = ST_OUT_RD;
            end
          end else begin
            // idle CPU: fetch the next arrival to jump ahead
            ent_re  = 1'b1;
            state_d = ST_JUMP;
          end
        end else begin
          ring_re = 1'b1;
          head_d  = head_inc;
          len_d   = len_q - CNT_W'(1);
          state_d = ST_POP;
        end
      end

      ST_JUMP: begin
        if (rd_arr_ct > time_q) time_d = rd_arr_ct;
        ret_d   = 1'b0;
        state_d = ST_ADM_RD;
      end

      ST_POP: begin
        p_d     = ring_rdata;
        rem_re  = 1'b1;
        state_d = ST_SLICE;
      end

      ST_SLICE: begin
        time_d    = time_q + CT_W'(slice);
        rem_d     = rem_rdata - slice;
        rem_we    = 1'b1;
        rem_wdata = rem_rdata - slice;
        ret_d     = 1'b1;
        state_d   = ST_ADM_RD;
      end

      ST_REQUEUE: begin
        // new arrivals are already in the ring ahead of the preempted process
        if (rem_q != '0) begin
          ring_we    = 1'b1;
          ring_wdata = p_q;
          tail_d     = tail_inc;
          len_d      = len_q + CNT_W'(1);
        end else begin
          fin_we = 1'b1;
        end
        ret_d   = 1'b0;
        state_d = ST_DISPATCH;
      end

      ST_OUT_RD: begin
        ent_re    = 1'b1;
        ent_raddr = ctr_q[IDX_W-1:0];
        fin_re    = 1'b1;
        state_d   = ST_OUT_LD;
      end

      ST_OUT_LD: begin
        if (res_free_i) begin
          res_ctl_o.load     = 1'b1;
          res_ctl_o.last     = (ctr_p1 == cnt_q);
          res_ctl_o.overflow = dropped_q;
          if (ctr_p1 == cnt_q) begin
            set_done = 1'b1;
          end else begin
            ctr_d   = ctr_p1;
            state_d = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (set_done) begin
      state_d   = ST_LOAD;
      cnt_d     = '0;
      dropped_d = 1'b0;
      time_d    = '0;
      na_d      = '0;
      head_d    = '0;
      tail_d    = '0;
      len_d     = '0;
      ctr_d     = '0;
      cpipe_d   = 1'b0;
      ret_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pos_q     <= '0;
      ctr_q     <= '0;
      na_q      <= '0;
      len_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      time_q    <= '0;
      dropped_q <= 1'b0;
      last_q    <= 1'b0;
      cpipe_q   <= 1'b0;
      ret_q     <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      ctr_q     <= ctr_d;
      na_q      <= na_d;
      len_q     <= len_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      time_q    <= time_d;
      dropped_q <= dropped_d;
      last_q    <= last_d;
      cpipe_q   <= cpipe_d;
      ret_q     <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    p_q    <= p_d;
    rem_q  <= rem_d;
  end

endmodule

// ===== src/rr_result.sv =====
// Result formatter: derives turnaround and waiting times, saturates and holds
// them in the output register. Uses rr_pkg and rr_res_if.
module rr_result #(
  parameter int unsigned MAX_PROCS = rr_pkg::MAX_PROCS_DEF,
  parameter int unsigned TIME_BITS = rr_pkg::TIME_BITS_DEF,
  localparam int unsigned IDX_W    = $clog2(MAX_PROCS),
  localparam int unsigned CT_W     = TIME_BITS + IDX_W + 1,
  localparam int unsigned ENT_W    = rr_pkg::ID_W + 2 * TIME_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rr_pkg::res_ctl_t ctl_i,
  input  logic [ENT_W-1:0] ent_i,
  input  logic [CT_W-1:0]  fin_i,
  output logic             free_o,
  rr_res_if.source         res_o
);
  import rr_pkg::*;

  localparam int unsigned SW = (CT_W > OUT_W) ? CT_W : OUT_W;

  logic             valid_q, valid_d;
  logic [ID_W-1:0]  id_q;
  logic [OUT_W-1:0] ct_q, tat_q, wt_q;
  logic             ovf_q, last_q;

  logic [CT_W-1:0]  tat, wt;
  logic [SW-1:0]    ct_x, tat_x, wt_x;

  assign tat  = fin_i - CT_W'(ent_i[2*TIME_BITS-1:TIME_BITS]);
  assign wt   = tat - CT_W'(ent_i[TIME_BITS-1:0]);
  assign ct_x  = SW'(fin_i);
  assign tat_x = SW'(tat);
  assign wt_x  = SW'(wt);

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = ctl_i.load ? 1'b1 : (res_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      id_q   <= ent_i[ENT_W-1 -: ID_W];
      ct_q   <= (ct_x > SW'(OUT_MAX)) ? OUT_MAX : ct_x[OUT_W-1:0];
      tat_q  <= (tat_x > SW'(OUT_MAX)) ? OUT_MAX : tat_x[OUT_W-1:0];
      wt_q   <= (wt_x > SW'(OUT_MAX)) ? OUT_MAX : wt_x[OUT_W-1:0];
      ovf_q  <= ctl_i.overflow;
      last_q <= ctl_i.last;
    end
  end

  assign res_o.valid           = valid_q;
  assign res_o.process_id_res  = id_q;
  assign res_o.completion_time = ct_q;
  assign res_o.turnaround_time = tat_q;
  assign res_o.waiting_time    = wt_q;
  assign res_o.overflow        = ovf_q;
  assign res_o.last_result     = last_q;

endmodule

// ===== src/round_robin_completion_times.sv =====
// Round-robin completion times. A load into an empty table is written directly and one
// into a full table is dropped; otherwise an insertion walk moves each stored entry with
// a later arrival up one slot. After the last load the remaining times are seeded, then
// slices are run with arrivals admitted after each one and idle gaps jumped, and then
// the results are sent in order, held while the receiver stalls. Inputs wait until the set is out.
// Reset clears control state and sets the quantum to 4; tables are written before read.
module round_robin_completion_times #(
  parameter int unsigned MAX_PROCS = rr_pkg::MAX_PROCS_DEF,
  parameter int unsigned TIME_BITS = rr_pkg::TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  rr_in_if.sink                  in_i,
  rr_res_if.source               res_o,
  input  logic                   cfg_we_i,
  input  logic [rr_pkg::Q_W-1:0] cfg_wdata_i
);
  import rr_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_PROCS);
  localparam int unsigned CT_W  = TIME_BITS + IDX_W + 1;
  localparam int unsigned ENT_W = ID_W + 2 * TIME_BITS;

  logic [Q_W-1:0]   quantum_q;
  logic             res_free;
  res_ctl_t         res_ctl;
  logic [ENT_W-1:0] ent;
  logic [CT_W-1:0]  fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= Q_RESET;
    end else if (cfg_we_i) begin
      quantum_q <= cfg_wdata_i;
    end
  end

  rr_sched #(.MAX_PROCS(MAX_PROCS), .TIME_BITS(TIME_BITS)) u_sched (
    .clk_i,
    .rst_ni,
    .in_i,
    .quantum_i  (quantum_q),
    .res_free_i (res_free),
    .res_ctl_o  (res_ctl),
    .ent_o      (ent),
    .fin_o      (fin)
  );

  rr_result #(.MAX_PROCS(MAX_PROCS), .TIME_BITS(TIME_BITS)) u_result (
    .clk_i,
    .rst_ni,
    .ctl_i  (res_ctl),
    .ent_i  (ent),
    .fin_i  (fin),
    .free_o (res_free),
    .res_o
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for round_robin_completion_times: loads process sets,
// predicts round-robin completion, turnaround and waiting times, checks each record.
// Depends on rr_pkg, rr_in_if, rr_res_if and the block itself.
module testbench;
  import rr_pkg::*;

  localparam int unsigned SLOTS       = MAX_PROCS_DEF;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_LOADS = 40;

  typedef struct {
    logic [ID_W-1:0]  pid;
    logic [OUT_W-1:0] done_at;
    logic [OUT_W-1:0] turnaround;
    logic [OUT_W-1:0] waited;
    logic             ovf;
    logic             is_last;
  } timing_rec_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [Q_W-1:0] cfg_wdata;

  rr_in_if  in_ch ();
  rr_res_if res_ch ();

  round_robin_completion_times DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Predictor state
  logic [IN_TIME_W-1:0] arr_tab   [SLOTS];
  logic [IN_TIME_W-1:0] burst_tab [SLOTS];
  logic [ID_W-1:0]      id_tab    [SLOTS];
  logic [IN_TIME_W-1:0] left_tab  [SLOTS];
  logic [OUT_W-1:0]     done_tab  [SLOTS];
  int unsigned          n_loaded;
  logic                 dropped;
  logic [Q_W-1:0]       quantum_q;
  logic [OUT_W-1:0]     clock_now;
  int unsigned          next_in;
  int                   run_queue [$];

  timing_rec_t timing_due [$];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned records_checked;
  int unsigned loads_sent;
  int unsigned sets_sent;
  int unsigned quantum_writes;
  int unsigned hold_off_req;
  bit          no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("round_robin_completion_times: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [OUT_W-1:0] sat_out(input longint unsigned v);
    return (v > longint'(OUT_MAX)) ? OUT_MAX : OUT_W'(v);
  endfunction

  task automatic admit_arrived();
    while (next_in < n_loaded && arr_tab[next_in] <= clock_now) begin
      run_queue.insert(run_queue.size(), int'(next_in));
      next_in++;
    end
  endtask

  task automatic schedule_set();
    logic [Q_W-1:0]       q;
    logic [IN_TIME_W-1:0] slice;
    int                   p;
    timing_rec_t          rec;
    longint unsigned      tat;
    q = (quantum_q == '0) ? Q_W'(1) : quantum_q;
    for (int i = 0; i < n_loaded; i++) left_tab[i] = burst_tab[i];
    clock_now = '0;
    next_in = 0;
    run_queue.delete();
    admit_arrived();
    while (1) begin
      if (run_queue.size() == 0) begin
        if (next_in >= n_loaded) break;
        // CPU idle: jump straight to the next arrival
        if (arr_tab[next_in] > clock_now) clock_now = OUT_W'(arr_tab[next_in]);
        admit_arrived();
        continue;
      end
      p = run_queue[0];
      run_queue.delete(0);
      slice = (left_tab[p] < q) ? left_tab[p] : q;
      clock_now += OUT_W'(slice);
      left_tab[p] -= slice;
      // fresh arrivals go ahead of the preempted process
      admit_arrived();
      if (left_tab[p] > 0) run_queue.insert(run_queue.size(), p);
      else done_tab[p] = clock_now;
    end
    for (int i = 0; i < n_loaded; i++) begin
      tat = longint'(done_tab[i]) - longint'(arr_tab[i]);
      rec.pid        = id_tab[i];
      rec.done_at    = sat_out(done_tab[i]);
      rec.turnaround = sat_out(tat);
      rec.waited     = sat_out(tat - longint'(burst_tab[i]));
      rec.ovf        = dropped;
      rec.is_last    = (i + 1 == n_loaded);
      timing_due.insert(timing_due.size(), rec);
    end
    n_loaded = 0;
    dropped = 1'b0;
  endtask

  task automatic load_process(input logic [ID_W-1:0] pid, input logic [IN_TIME_W-1:0] at,
                              input logic [IN_TIME_W-1:0] bt, input logic last);
    int unsigned pos;
    if (n_loaded < SLOTS) begin
      // insertion keeps equal arrivals in load order
      pos = n_loaded;
      while (pos > 0 && arr_tab[pos-1] > at) begin
        arr_tab[pos]   = arr_tab[pos-1];
        burst_tab[pos] = burst_tab[pos-1];
        id_tab[pos]    = id_tab[pos-1];
        pos--;
      end
      arr_tab[pos]   = at;
      burst_tab[pos] = bt;
      id_tab[pos]    = pid;
      n_loaded++;
      loads_sent++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      schedule_set();
      sets_sent++;
    end
  endtask

  task automatic send_proc(input logic [ID_W-1:0] pid, input logic [IN_TIME_W-1:0] at,
                           input logic [IN_TIME_W-1:0] bt, input logic last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.process_id   <= pid;
    in_ch.arrival_time <= at;
    in_ch.burst_time   <= bt;
    in_ch.last_process <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    load_process(pid, at, bt, last);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (timing_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [Q_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    quantum_q = v;
    quantum_writes++;
  endtask

  task automatic send_random_set(input int unsigned n);
    logic [IN_TIME_W-1:0] at, bt, prev_at;
    int unsigned r;
    prev_at = '0;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      at = IN_TIME_W'($urandom_range(0, 40));
      else if (r < 75) at = IN_TIME_W'($urandom_range(0, 65535));
      else if (r < 90) at = prev_at;
      else             at = IN_TIME_W'(32'hFFFF - $urandom_range(0, 3));
      prev_at = at;
      r = $urandom_range(0, 99);
      // long bursts only where the quantum keeps the slice count down
      if (r < 3)                              bt = '0;
      else if (quantum_q >= 1024 && r < 40)   bt = IN_TIME_W'($urandom_range(1, 65535));
      else                                    bt = IN_TIME_W'($urandom_range(1, 24));
      send_proc(ID_W'($urandom_range(0, 255)), at, bt, i + 1 == n);
    end
  endtask

  // Result side: random stalls, an occasional long hold-off, one check per transfer
  initial begin
    int unsigned stall;
    timing_rec_t want;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req > 0) begin
        stall = hold_off_req;
        hold_off_req = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      if (timing_due.size() == 0) begin
        report_mismatch("record with nothing pending, id", res_ch.process_id_res, 0);
      end else begin
        want = timing_due[0];
        timing_due.delete(0);
        records_checked++;
        if (res_ch.process_id_res !== want.pid)
          report_mismatch("process_id_res", res_ch.process_id_res, want.pid);
        if (res_ch.completion_time !== want.done_at)
          report_mismatch("completion_time", res_ch.completion_time, want.done_at);
        if (res_ch.turnaround_time !== want.turnaround)
          report_mismatch("turnaround_time", res_ch.turnaround_time, want.turnaround);
        if (res_ch.waiting_time !== want.waited)
          report_mismatch("waiting_time", res_ch.waiting_time, want.waited);
        if (res_ch.overflow !== want.ovf)
          report_mismatch("overflow", res_ch.overflow, want.ovf);
        if (res_ch.last_result !== want.is_last)
          report_mismatch("last_result", res_ch.last_result, want.is_last);
      end
    end
  end

  task automatic test_extremes();
    // reset quantum of 4 first
    send_proc(8'h00, 16'd0, 16'd1, 1'b1);
    send_proc(8'h5A, 16'd0, 16'd9, 1'b0);
    send_proc(8'hA5, 16'd1, 16'd6, 1'b1);
    wait_idle();
    write_quantum(16'hFFFF);
    send_proc(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_ordering();
    write_quantum(16'd2);
    // loaded out of order; two equal arrivals land exactly when a slice ends
    send_proc(8'd1, 16'd5, 16'd3, 1'b0);
    send_proc(8'd2, 16'd0, 16'd5, 1'b0);
    send_proc(8'd3, 16'd2, 16'd2, 1'b0);
    send_proc(8'd4, 16'd2, 16'd1, 1'b1);
    // gap in arrivals leaves the CPU idle
    send_proc(8'd6, 16'd0, 16'd2, 1'b0);
    send_proc(8'd7, 16'd100, 16'd3, 1'b1);
    wait_idle();
  endtask

  task automatic test_zero_cases();
    write_quantum(16'd0);
    send_proc(8'd20, 16'd0, 16'd0, 1'b0);
    send_proc(8'd21, 16'd0, 16'd3, 1'b0);
    send_proc(8'd22, 16'd1, 16'd0, 1'b0);
    send_proc(8'd23, 16'd1, 16'd2, 1'b1);
    wait_idle();
    write_quantum(16'd1);
    send_proc(8'd24, 16'd0, 16'd4, 1'b0);
    send_proc(8'd25, 16'd0, 16'd4, 1'b1);
    wait_idle();
  endtask

  task automatic test_overflow();
    write_quantum(16'd3);
    // more loads than slots; the dropped final load still starts the run
    send_random_set(SLOTS + 2);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_quantum(16'd5);
    hold_off_req = 400;
    send_random_set(SLOTS);
    send_random_set(6);
    wait_idle();
  endtask

  task automatic test_random_sets();
    int unsigned loads, rounds, n;
    logic [Q_W-1:0] q;
    loads = 0;
    rounds = 0;
    while (loads < RANDOM_LOADS) begin
      if (rounds % 3 == 0) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0:       q = 16'd1;
          1:       q = 16'd2;
          2:       q = Q_W'($urandom_range(3, 8));
          3:       q = Q_W'($urandom_range(9, 1023));
          4:       q = Q_W'($urandom_range(1024, 65535));
          default: q = 16'hFFFF;
        endcase
        write_quantum(q);
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0:       n = $urandom_range(SLOTS + 1, SLOTS + 4);
        1, 2:    n = $urandom_range(20, SLOTS);
        default: n = $urandom_range(1, 8);
      endcase
      send_random_set(n);
      loads += (n > SLOTS) ? SLOTS : n;
      rounds++;
    end
    wait_idle();
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.process_id   <= '0;
    in_ch.arrival_time <= '0;
    in_ch.burst_time   <= '0;
    in_ch.last_process <= 1'b0;
    n_loaded = 0;
    dropped = 1'b0;
    quantum_q = Q_RESET;
    mismatches = 0;
    records_checked = 0;
    loads_sent = 0;
    sets_sent = 0;
    quantum_writes = 0;
    hold_off_req = 0;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_ordering();
    test_zero_cases();
    test_overflow();
    test_backpressure();
    test_random_sets();
    wait_idle();

    $display("Ran %0d process sets, %0d processes stored, %0d timing records checked,",
             sets_sent, loads_sent, records_checked);
    $display("over %0d quantum settings incl. 0, 1 and 65535, overflow and a long stall.",
             quantum_writes);
    if (mismatches == 0) begin
      $display("round_robin_completion_times: match");
    end else begin
      $display("round_robin_completion_times: mismatch");
    end
    $finish;
  end

endmodule
